[sv/cokm_pkg.sv]
`default_nettype none
package cokm_pkg;

  // Fixed geometry of the block
  localparam int NUM_REFS   = 4;   // reference colors compared per pixel
  localparam int COORD_BITS = 10;  // significant bits of row and col
  localparam int REG_REFS   = 4;   // reference color registers present
  localparam int REF_IDX_W  = $clog2(REG_REFS);

  localparam int CHAN_W   = 8;
  localparam int THR_W    = 7;
  localparam int RCNT_W   = 3;
  localparam int COLOR_W  = 24;
  localparam int COORD_W  = 10;
  localparam int SUM_W    = 30;
  localparam int CNT_W    = 21;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(30);
  localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(255);

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 3'd0,
    REG_REF_COUNT     = 3'd1,
    REG_REF_COLOR_0   = 3'd2,
    REG_REF_COLOR_1   = 3'd3,
    REG_REF_COLOR_2   = 3'd4,
    REG_REF_COLOR_3   = 3'd5,
    REG_CENTER_ENABLE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACC,
    ST_ROW_GO,
    ST_ROW_WAIT,
    ST_COL_GO,
    ST_COL_WAIT,
    ST_FIN
  } st_t;

  // Divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[sv/cokm_cmp.sv]
`default_nettype none
// One reference color against one pixel: all three channels strictly inside
// the window (ref - thr, ref + thr).
module cokm_cmp (
  input  var cokm_pkg::pix_t                      pix,
  input  var logic [cokm_pkg::COLOR_W-1:0]        ref_color,
  input  var logic [cokm_pkg::THR_W-1:0]          thr,
  output logic                                    hit
);
  import cokm_pkg::*;

  pix_t ref_pix;
  logic ok_r, ok_g, ok_b;

  function automatic logic in_win(input logic [CHAN_W-1:0] p,
                                  input logic [CHAN_W-1:0] rv,
                                  input logic [THR_W-1:0]  t);
    logic [CHAN_W:0] p_ext, r_ext, t_ext;
    p_ext = {1'b0, p};
    r_ext = {1'b0, rv};
    t_ext = (CHAN_W+1)'(t);
    // p < r + t  and  p + t > r, no negative values needed
    return (p_ext < r_ext + t_ext) && (p_ext + t_ext > r_ext);
  endfunction

  assign ref_pix = pix_t'(ref_color);

  always_comb begin
    ok_r = in_win(pix.red,   ref_pix.red,   thr);
    ok_g = in_win(pix.green, ref_pix.green, thr);
    ok_b = in_win(pix.blue,  ref_pix.blue,  thr);
    hit  = ok_r && ok_g && ok_b;
  end

endmodule
`default_nettype wire

[sv/cokm_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module cokm_div #(
  parameter int DVD_W = cokm_pkg::SUM_W,
  parameter int DVS_W = cokm_pkg::CNT_W
) (
  input  var logic                 clk,
  input  var logic                 rst_n,
  input  var logic                 start,
  input  var logic [DVD_W-1:0]     dividend,
  input  var logic [DVS_W-1:0]     divisor,
  output logic [DVD_W-1:0]         quotient,
  output cokm_pkg::div_stat_t      stat
);
  import cokm_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial, diff;
  logic             qbit;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    qbit     = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], qbit};
      rem_nxt = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

[sv/color_key_match_centroid.sv]
`default_nettype none
// Color key match with centroid, one pixel word at a time.
// The references are tried in order, stopping at the first hit; a last pixel with
//   centering on and matches present then runs two divisions, row sum then col sum.
// A new word is taken only once the result of the last one is loaded; out_tready low
//   holds that load back.
// Reset: synchronous active-low rst_n; threshold 30, center enable on, sums clear.
module color_key_match_centroid (
  input  var logic                              clk,
  input  var logic                              rst_n,
  // pixel input
  input  var logic                              in_tvalid,
  output logic                                  in_tready,
  // blue[7:0], green[15:8], red[23:16], row[33:24], col[43:34], zero[47:44]
  input  var logic [cokm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  var logic                              in_tlast,   // last_in_frame
  // result output
  output logic                                  out_tvalid,
  input  var logic                              out_tready,
  // mask[0], center_valid[1], center_row[11:2], center_col[21:12], zero[23:22]
  output logic [cokm_pkg::OUT_DATA_W-1:0]       out_tdata,
  // config write port
  input  var logic                              cfg_we,
  input  var logic [cokm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  var logic [cokm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cokm_pkg::*;

  localparam int REF_LIM = (NUM_REFS < REG_REFS) ? NUM_REFS : REG_REFS;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'((1 << COORD_BITS) - 1);

  // ---------------------------------------------------------------- config
  logic [THR_W-1:0]   thr_r;
  logic [RCNT_W-1:0]  rcnt_r;
  logic [COLOR_W-1:0] color_r [REG_REFS];
  logic               cen_en_r;

  // ---------------------------------------------------------------- state
  st_t                state_r, state_nxt;
  pix_t               pix_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic               last_r;
  logic [RCNT_W-1:0]  ref_idx_r;
  logic               hit_r;

  logic [SUM_W-1:0]   row_sum_r, col_sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0] lc_row_r, lc_col_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // ---------------------------------------------------------------- datapath
  logic               in_acc;
  logic [RCNT_W-1:0]  n_eff;
  logic               idx_live;
  logic               cmp_hit;

  logic               add_en;
  logic [SUM_W:0]     row_add, col_add;
  logic [CNT_W:0]     cnt_add;
  logic [SUM_W-1:0]   row_sum_acc, col_sum_acc;
  logic [CNT_W-1:0]   cnt_acc;

  logic               div_start;
  logic [SUM_W-1:0]   div_dvd;
  logic [SUM_W-1:0]   div_quo;
  div_stat_t          div_stat;
  logic [COORD_W-1:0] quo_clamp;

  // sequencer strobes
  logic cmp_step, acc_step, row_cap, col_cap, load_out;

  logic                  res_cv;
  logic [COORD_W-1:0]    res_row, res_col;

  assign in_acc = in_tvalid && in_tready;

  // active reference count, clamped to what exists
  assign n_eff    = (rcnt_r > RCNT_W'(REF_LIM)) ? RCNT_W'(REF_LIM) : rcnt_r;
  assign idx_live = (ref_idx_r < n_eff);

  // shared compare unit: one reference per cycle
  cokm_cmp u_cmp (
    .pix       (pix_r),
    .ref_color (color_r[ref_idx_r[REF_IDX_W-1:0]]),
    .thr       (thr_r),
    .hit       (cmp_hit)
  );

  // saturating accumulate
  always_comb begin
    add_en      = cen_en_r && hit_r;
    row_add     = {1'b0, row_sum_r} + (SUM_W+1)'(row_r[COORD_BITS-1:0]);
    col_add     = {1'b0, col_sum_r} + (SUM_W+1)'(col_r[COORD_BITS-1:0]);
    cnt_add     = {1'b0, cnt_r} + (CNT_W+1)'(1);
    row_sum_acc = row_sum_r;
    col_sum_acc = col_sum_r;
    cnt_acc     = cnt_r;
    if (add_en) begin
      row_sum_acc = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
      col_sum_acc = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
      cnt_acc     = cnt_add[CNT_W] ? CNT_MAX : cnt_add[CNT_W-1:0];
    end
  end

  // shared divider, row sum first then col sum
  assign div_dvd = (state_r == ST_COL_GO) ? col_sum_r : row_sum_r;

  cokm_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cnt_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // clamp average to largest coordinate
  assign quo_clamp = (|div_quo[SUM_W-1:COORD_BITS]) ? COORD_MAX
                                                    : COORD_W'(div_quo[COORD_BITS-1:0]);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_CMP;
      ST_CMP:      if (!idx_live || cmp_hit) state_nxt = ST_ACC;
      ST_ACC: begin
        if (last_r && cen_en_r && (cnt_acc != '0)) begin
          state_nxt = ST_ROW_GO;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_ROW_GO:   state_nxt = ST_ROW_WAIT;
      ST_ROW_WAIT: if (div_stat.done) state_nxt = ST_COL_GO;
      ST_COL_GO:   state_nxt = ST_COL_WAIT;
      ST_COL_WAIT: if (div_stat.done) state_nxt = ST_FIN;
      ST_FIN:      if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_tready = 1'b0;
    cmp_step  = 1'b0;
    acc_step  = 1'b0;
    div_start = 1'b0;
    row_cap   = 1'b0;
    col_cap   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE:     in_tready = rst_n;   // no word taken while in reset
      ST_CMP:      cmp_step  = 1'b1;
      ST_ACC:      acc_step  = 1'b1;
      ST_ROW_GO:   div_start = 1'b1;
      ST_ROW_WAIT: row_cap   = div_stat.done;
      ST_COL_GO:   div_start = 1'b1;
      ST_COL_WAIT: col_cap   = div_stat.done;
      ST_FIN:      load_out  = !out_tvalid_r || out_tready;
      default:     in_tready = 1'b0;
    endcase
  end

  // result word
  always_comb begin
    res_cv  = last_r && cen_en_r;
    res_row = res_cv ? lc_row_r : '0;
    res_col = res_cv ? lc_col_r : '0;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      ref_idx_r    <= '0;
      hit_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (in_acc) begin
        ref_idx_r <= '0;
        hit_r     <= 1'b0;
      end else if (cmp_step && idx_live) begin
        if (cmp_hit) begin
          hit_r <= 1'b1;
        end else begin
          ref_idx_r <= ref_idx_r + RCNT_W'(1);
        end
      end
    end
  end

  // pixel capture and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r.blue  <= in_tdata[7:0];
      pix_r.green <= in_tdata[15:8];
      pix_r.red   <= in_tdata[23:16];
      row_r       <= in_tdata[33:24];
      col_r       <= in_tdata[43:34];
      last_r      <= in_tlast;
    end
    if (load_out) begin
      out_data_r <= {2'b00, res_col, res_row, res_cv, hit_r};
    end
  end

  // config registers, sums and stored centroid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RESET;
      rcnt_r    <= '0;
      for (int i = 0; i < REG_REFS; i++) begin
        color_r[i] <= '0;
      end
      cen_en_r  <= 1'b1;
      row_sum_r <= '0;
      col_sum_r <= '0;
      cnt_r     <= '0;
      lc_row_r  <= '0;
      lc_col_r  <= '0;
    end else begin
      if (acc_step) begin
        row_sum_r <= row_sum_acc;
        col_sum_r <= col_sum_acc;
        cnt_r     <= cnt_acc;
      end
      if (row_cap) lc_row_r <= quo_clamp;
      if (col_cap) lc_col_r <= quo_clamp;
      // frame done: start next one with clear sums
      if (load_out && last_r) begin
        row_sum_r <= '0;
        col_sum_r <= '0;
        cnt_r     <= '0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:   thr_r      <= cfg_data[THR_W-1:0];
          REG_REF_COUNT:   rcnt_r     <= cfg_data[RCNT_W-1:0];
          REG_REF_COLOR_0: color_r[0] <= cfg_data;
          REG_REF_COLOR_1: color_r[1] <= cfg_data;
          REG_REF_COLOR_2: color_r[2] <= cfg_data;
          REG_REF_COLOR_3: color_r[3] <= cfg_data;
          REG_CENTER_ENABLE: begin
            cen_en_r  <= cfg_data[0];
            row_sum_r <= '0;
            col_sum_r <= '0;
            cnt_r     <= '0;
            lc_row_r  <= '0;
            lc_col_r  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- checks
  // no new word while the divider still runs
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // divider only started with a nonzero match count
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (cnt_r != '0))
    else $error("divide by zero count");

  // center fields are zero unless center_valid
  a_cv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_data_r[1]) |-> (out_data_r[21:2] == '0))
    else $error("center fields set without center_valid");

  // row quotient hands over to the column division
  a_row_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_WAIT && div_stat.done) |=> (state_r == ST_COL_GO))
    else $error("column division skipped");

endmodule
`default_nettype wire
